FILE: hdl/kdec_pkg.sv
// ----------------------------------------------------------------------------
// kdec_pkg
// shared types and constants for the key debounce event classifier
// ----------------------------------------------------------------------------
package kdec_pkg;

  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned TICK_W = 8;
  localparam int unsigned TALLY_W = 8;
  localparam logic [TALLY_W-1:0] TALLY_MAX = 8'd250;

  localparam logic [1:0] REG_CLICK  = 2'd0;
  localparam logic [1:0] REG_HOLD   = 2'd1;
  localparam logic [1:0] REG_REPEAT = 2'd2;

  localparam logic [TICK_W-1:0] CLICK_RST  = 8'd5;
  localparam logic [TICK_W-1:0] HOLD_RST   = 8'd100;
  localparam logic [TICK_W-1:0] REPEAT_RST = 8'd20;

  typedef enum logic [1:0] {
    PH_NONE   = 2'd0,
    PH_DOWN   = 2'd1,
    PH_HOLD   = 2'd2,
    PH_REPEAT = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    KIND_PLAIN   = 3'd0,
    KIND_DOWN    = 3'd1,
    KIND_HOLD    = 3'd2,
    KIND_REPEAT  = 3'd3,
    KIND_UP      = 3'd4,
    KIND_LONG_UP = 3'd5
  } kind_e;

endpackage

FILE: hdl/key_debounce_event_classifier_unit.sv
// ----------------------------------------------------------------------------
// key_debounce_event_classifier_unit
// debounces scanned key codes and classifies press, hold, repeat and release
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  in       | in_valid_i / in_ready_o | key_sample_i, suppress_set_i
//  out      | out_valid_o/ out_ready_i| press_pulse_o, event_key_o,
//           |                         | event_kind_o, long_count_o
//  cfg      | apb psel/penable/pready | click, hold, repeat tick registers
//
//  one beat per cycle while in_ready_o is high; each beat updates the state at
//  its accept edge, and its result goes to the main output register, or to the
//  skid register when main is full and not popped; the two entries let input
//  beats flow on while the output stalls; in_ready_o drops only when both are
//  full; reset clears key state and valid flags; ticks return to 5, 100, 20
// ----------------------------------------------------------------------------
module key_debounce_event_classifier_unit
  import kdec_pkg::*;
#(
  parameter int unsigned KEY_BITS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KEY_BITS-1:0] key_sample_i,
  input  logic                suppress_set_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                press_pulse_o,
  output logic [KEY_BITS-1:0] event_key_o,
  output logic [2:0]          event_kind_o,
  output logic [TALLY_W-1:0]  long_count_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

  logic [TICK_W-1:0] click_q, hold_q, repeat_q;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      click_q  <= CLICK_RST;
      hold_q   <= HOLD_RST;
      repeat_q <= REPEAT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CLICK:  click_q  <= pwdata[TICK_W-1:0];
        REG_HOLD:   hold_q   <= pwdata[TICK_W-1:0];
        REG_REPEAT: repeat_q <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CLICK:  prdata = {{(CFG_DW-TICK_W){1'b0}}, click_q};
      REG_HOLD:   prdata = {{(CFG_DW-TICK_W){1'b0}}, hold_q};
      REG_REPEAT: prdata = {{(CFG_DW-TICK_W){1'b0}}, repeat_q};
      default:    prdata = '0;
    endcase
  end

  // key state
  logic [KEY_BITS-1:0] cand_q, cand_d, stable_q, stable_d, prev_q, prev_d;
  phase_e              phase_q, phase_d;
  logic [TICK_W-1:0]   cnt_q, cnt_d, cnt_dec;
  logic [TALLY_W-1:0]  tally_q, tally_d;
  logic                supp_q, supp_d, supp_eff;
  logic [KEY_BITS-1:0] ev_key_q, ev_key_d;
  kind_e               ev_kind_q, ev_kind_d;
  logic                pulse;
  logic                in_acc;

  assign in_acc   = in_valid_i & in_ready_o;
  assign supp_eff = supp_q | suppress_set_i;
  assign cnt_dec  = cnt_q - 1'b1;

  always_comb begin
    cand_d    = cand_q;
    stable_d  = stable_q;
    prev_d    = prev_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    tally_d   = tally_q;
    supp_d    = supp_eff;
    ev_key_d  = ev_key_q;
    ev_kind_d = ev_kind_q;
    pulse     = 1'b0;
    if (stable_q != key_sample_i) begin
      if (cand_q != key_sample_i) begin
        cand_d = key_sample_i;
      end else begin
        stable_d = key_sample_i;
      end
    end else if (stable_q == prev_q) begin
      if (prev_q != '0 && cnt_q != '0) begin
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          pulse    = ~supp_eff;
          ev_key_d = prev_q;
          case (phase_q)
            PH_NONE: begin
              phase_d   = PH_DOWN;
              ev_kind_d = KIND_DOWN;
              cnt_d     = hold_q;
            end
            PH_DOWN: begin
              phase_d   = PH_HOLD;
              ev_kind_d = KIND_HOLD;
              cnt_d     = repeat_q;
            end
            default: begin
              phase_d   = PH_REPEAT;
              ev_kind_d = KIND_REPEAT;
              cnt_d     = repeat_q;
              if (tally_q < TALLY_MAX) begin
                tally_d = tally_q + 1'b1;
              end
            end
          endcase
        end
      end
    end else begin
      if (prev_q != '0) begin
        pulse    = ~supp_eff;
        ev_key_d = prev_q;
        case (phase_q)
          PH_NONE: ev_kind_d = KIND_PLAIN;
          PH_DOWN: ev_kind_d = KIND_UP;
          default: ev_kind_d = KIND_LONG_UP;
        endcase
        phase_d = PH_NONE;
      end else begin
        supp_d  = 1'b0;
        tally_d = '0;
      end
      cnt_d  = click_q;
      prev_d = stable_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q    <= '0;
      stable_q  <= '0;
      prev_q    <= '0;
      phase_q   <= PH_NONE;
      cnt_q     <= '0;
      tally_q   <= '0;
      supp_q    <= 1'b0;
      ev_key_q  <= '0;
      ev_kind_q <= KIND_PLAIN;
    end else if (in_acc) begin
      cand_q    <= cand_d;
      stable_q  <= stable_d;
      prev_q    <= prev_d;
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      tally_q   <= tally_d;
      supp_q    <= supp_d;
      ev_key_q  <= ev_key_d;
      ev_kind_q <= ev_kind_d;
    end
  end

  // output register with skid
  logic                out_vld_q, skid_vld_q;
  logic                o_pulse_q, s_pulse_q;
  logic [KEY_BITS-1:0] o_key_q, s_key_q;
  kind_e               o_kind_q, s_kind_q;
  logic [TALLY_W-1:0]  o_cnt_q, s_cnt_q;
  logic                out_pop, load_out;

  assign in_ready_o = ~skid_vld_q;
  assign out_pop    = out_vld_q & out_ready_i;
  assign load_out   = in_acc & (~out_vld_q | out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_pop && !skid_vld_q) begin
        out_vld_q <= 1'b0;
      end
      if (out_pop && skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else if (in_acc && !load_out) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_pulse_q <= pulse;
      o_key_q   <= ev_key_d;
      o_kind_q  <= ev_kind_d;
      o_cnt_q   <= tally_d;
    end else if (out_pop && skid_vld_q) begin
      o_pulse_q <= s_pulse_q;
      o_key_q   <= s_key_q;
      o_kind_q  <= s_kind_q;
      o_cnt_q   <= s_cnt_q;
    end
    if (in_acc && !load_out) begin
      s_pulse_q <= pulse;
      s_key_q   <= ev_key_d;
      s_kind_q  <= ev_kind_d;
      s_cnt_q   <= tally_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign press_pulse_o = o_pulse_q;
  assign event_key_o   = o_key_q;
  assign event_kind_o  = o_kind_q;
  assign long_count_o  = o_cnt_q;

endmodule
